[sv/slp_pkg.sv]
// Shared types and constants of the sidelobe partial sequence pruner.
`default_nettype none
package slp_pkg;

   localparam logic       ACTION_ASSIGN    = 1'b0;
   localparam logic       ACTION_UNDO      = 1'b1;

   localparam logic [1:0] ST_FEASIBLE      = 2'd0;
   localparam logic [1:0] ST_INFEASIBLE    = 2'd1;
   localparam logic [1:0] ST_REJECTED      = 2'd2;
   localparam logic [1:0] ST_ILLEGAL       = 2'd3;

   localparam logic       CSR_SIDELOBE_BOUND = 1'b0;
   localparam logic [6:0] BOUND_RESET      = 7'd4;

   typedef enum logic [2:0] {
      DP_IDLE,
      DP_PLACE_LEFT,
      DP_PLACE_RIGHT,
      DP_REMOVE_RIGHT,
      DP_REMOVE_LEFT,
      DP_CHECK,
      DP_REDUCE
   } dp_op_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_PLACE_LEFT,
      CTL_PLACE_RIGHT,
      CTL_REMOVE_RIGHT,
      CTL_REMOVE_LEFT,
      CTL_CHECK,
      CTL_REDUCE
   } ctl_state_type;

   typedef struct packed {
      dp_op_type  op;
      logic       left_spin;
      logic       right_spin;
      logic       use_check;
      logic [1:0] code;
   } cmd_type;

   typedef struct packed {
      logic at_full;
      logic at_root;
      logic order_open;
   } stat_type;

endpackage
`default_nettype wire

[sv/slp_datapath.sv]
// Datapath: spins, fixed mask, per-lag correlation lanes, bound check and peak tree.
`default_nettype none
module slp_datapath #(
   parameter int SEQ_LENGTH = 70
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire slp_pkg::cmd_type    cmd,
   input  wire [6:0]                sidelobe_bound,
   output slp_pkg::stat_type        stat,
   output logic [1:0]               status,
   output logic [6:0]               fill_depth,
   output logic                     complete,
   output logic [6:0]               peak_magnitude
);
   localparam int  N    = SEQ_LENGTH;
   localparam int  HALF = N / 2;
   localparam int  PW   = $clog2(N);
   localparam int  DW   = $clog2(HALF + 1);
   localparam int  P    = 1 << PW;
   localparam bit  EVEN = (N % 2) == 0;

   logic [N-1:0]        spin_ff, spin_in, mask_ff, mask_in, mrev;
   logic [N-1:0]        mhi, mlo, shi, slo, srev;
   logic signed [7:0]   corr_ff [N-1:1];
   logic signed [7:0]   corr_in [N-1:1];
   logic [6:0]          prod_ff [N-1:1];
   logic [6:0]          prod_in [N-1:1];
   logic [6:0]          mag_ff  [N-1:1];
   logic [6:0]          mag_in  [N-1:1];
   logic [N-1:1]        ok_ff, ok_in, inb_ff, inb_in;
   logic [DW-1:0]       depth_ff, depth_in, brk_depth_ff, brk_depth_in;
   logic                brk_valid_ff, brk_valid_in;
   logic [PW-1:0]       pos;
   logic                spin, add, lane_en, brk_active;
   logic [1:0]          status_ff;
   logic [6:0]          fill_ff, peak_ff;
   logic                complete_ff;
   logic [6:0]          node [1:2*P-1];

   assign brk_active      = brk_valid_ff && (brk_depth_ff <= depth_ff);
   assign stat.at_full    = depth_ff == DW'(HALF);
   assign stat.at_root    = depth_ff == DW'(1);
   assign stat.order_open = !brk_active;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         mrev[i] = mask_ff[N-1-i];
         srev[i] = spin_ff[N-1-i];
      end
      unique case (cmd.op)
         slp_pkg::DP_PLACE_LEFT:   pos = PW'(depth_ff);
         slp_pkg::DP_PLACE_RIGHT:  pos = PW'(N - 1) - PW'(depth_ff);
         slp_pkg::DP_REMOVE_RIGHT: pos = PW'(N) - PW'(depth_ff);
         slp_pkg::DP_REMOVE_LEFT:  pos = PW'(depth_ff) - PW'(1);
         default:                  pos = '0;
      endcase
      add     = (cmd.op == slp_pkg::DP_PLACE_LEFT) || (cmd.op == slp_pkg::DP_PLACE_RIGHT);
      lane_en = add || (cmd.op == slp_pkg::DP_REMOVE_RIGHT)
                    || (cmd.op == slp_pkg::DP_REMOVE_LEFT);
      unique case (cmd.op)
         slp_pkg::DP_PLACE_LEFT:  spin = cmd.left_spin;
         slp_pkg::DP_PLACE_RIGHT: spin = cmd.right_spin;
         default:                 spin = spin_ff[pos];
      endcase
      mhi = mask_ff >> pos;
      shi = spin_ff >> pos;
      mlo = mrev >> (PW'(N - 1) - pos);
      slo = srev >> (PW'(N - 1) - pos);
   end

   always_comb begin
      logic [1:0]        cnt, mt;
      logic signed [7:0] d8;
      logic [7:0]        a8;
      logic [8:0]        lim;
      for (int l = 1; l < N; l++) begin
         cnt = 2'(mhi[l]) + 2'(mlo[l]);
         mt  = 2'(mhi[l] && (shi[l] == spin)) + 2'(mlo[l] && (slo[l] == spin));
         d8  = $signed({5'b0, mt, 1'b0}) - $signed({6'b0, cnt});
         corr_in[l] = corr_ff[l];
         prod_in[l] = prod_ff[l];
         if (lane_en) begin
            corr_in[l] = add ? corr_ff[l] + d8 : corr_ff[l] - d8;
            prod_in[l] = add ? prod_ff[l] + 7'(cnt) : prod_ff[l] - 7'(cnt);
         end
         a8        = corr_ff[l][7] ? 8'(-corr_ff[l]) : 8'(corr_ff[l]);
         mag_in[l] = a8[6:0];
         lim       = {2'b0, sidelobe_bound} + 9'(N - l) - {2'b0, prod_ff[l]};
         ok_in[l]  = {2'b0, a8[6:0]} <= lim;
         inb_in[l] = a8[6:0] <= sidelobe_bound;
      end
   end

   always_comb begin
      spin_in      = spin_ff;
      mask_in      = mask_ff;
      depth_in     = depth_ff;
      brk_valid_in = brk_valid_ff;
      brk_depth_in = brk_depth_ff;
      unique case (cmd.op)
         slp_pkg::DP_PLACE_LEFT: begin
            spin_in[pos] = spin;
            mask_in[pos] = 1'b1;
         end
         slp_pkg::DP_PLACE_RIGHT: begin
            spin_in[pos] = spin;
            mask_in[pos] = 1'b1;
            depth_in     = depth_ff + DW'(1);
            if (!brk_active && (cmd.left_spin != cmd.right_spin)) begin
               brk_valid_in = 1'b1;
               brk_depth_in = depth_ff + DW'(1);
            end
         end
         slp_pkg::DP_REMOVE_RIGHT: mask_in[pos] = 1'b0;
         slp_pkg::DP_REMOVE_LEFT: begin
            mask_in[pos] = 1'b0;
            depth_in     = depth_ff - DW'(1);
            if (brk_valid_ff && (brk_depth_ff == depth_ff)) brk_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   for (genvar i = 0; i < P; i++) begin : g_leaf
      if (i >= 1 && i < N) begin : g_used
         assign node[P+i] = mag_ff[i];
      end else begin : g_pad
         assign node[P+i] = 7'd0;
      end
   end
   for (genvar k = 1; k < P; k++) begin : g_tree
      assign node[k] = (node[2*k] > node[2*k+1]) ? node[2*k] : node[2*k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spin_ff      <= {1'b1, {(N-2){1'b0}}, 1'b1};
         mask_ff      <= {1'b1, {(N-2){1'b0}}, 1'b1};
         depth_ff     <= DW'(1);
         brk_valid_ff <= 1'b0;
         brk_depth_ff <= '0;
         for (int l = 1; l < N; l++) begin
            corr_ff[l] <= (l == N - 1) ? 8'sd1 : 8'sd0;
            prod_ff[l] <= (l == N - 1) ? 7'd1 : 7'd0;
         end
      end else begin
         spin_ff      <= spin_in;
         mask_ff      <= mask_in;
         depth_ff     <= depth_in;
         brk_valid_ff <= brk_valid_in;
         brk_depth_ff <= brk_depth_in;
         for (int l = 1; l < N; l++) begin
            corr_ff[l] <= corr_in[l];
            prod_ff[l] <= prod_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == slp_pkg::DP_CHECK) begin
         ok_ff  <= ok_in;
         inb_ff <= inb_in;
         for (int l = 1; l < N; l++) mag_ff[l] <= mag_in[l];
      end
      if (cmd.op == slp_pkg::DP_REDUCE) begin
         status_ff   <= cmd.use_check ? ((&ok_ff) ? slp_pkg::ST_FEASIBLE
                                                  : slp_pkg::ST_INFEASIBLE) : cmd.code;
         fill_ff     <= 7'(depth_ff);
         complete_ff <= EVEN && stat.at_full && (&inb_ff);
         peak_ff     <= node[1];
      end
   end

   assign status         = status_ff;
   assign fill_depth     = fill_ff;
   assign complete       = complete_ff;
   assign peak_magnitude = peak_ff;

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      depth_ff >= DW'(1) && depth_ff <= DW'(HALF))
      else $error("pair depth out of range");
   a_place_step: assert property (@(posedge clock) disable iff (reset)
      cmd.op == slp_pkg::DP_PLACE_RIGHT |=> depth_ff == $past(depth_ff) + DW'(1))
      else $error("pair depth did not advance");
   a_break_below: assert property (@(posedge clock) disable iff (reset)
      brk_valid_ff |-> brk_depth_ff <= depth_ff)
      else $error("order break above current depth");
endmodule
`default_nettype wire

[sv/slp_ctrl.sv]
// Controller: item sequencing, command issue and result handshake.
`default_nettype none
module slp_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire                    req_action,
   input  wire                    req_left,
   input  wire                    req_right,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   input  wire slp_pkg::stat_type stat,
   output slp_pkg::cmd_type       cmd
);
   slp_pkg::ctl_state_type state_ff, state_in;
   logic       left_ff, right_ff, use_check_ff, use_check_in, rsp_valid_ff, rsp_valid_in;
   logic [1:0] code_ff, code_in;
   logic       out_free, accept;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = (state_ff == slp_pkg::CTL_IDLE) && req_tvalid;

   always_comb begin
      state_in     = state_ff;
      use_check_in = use_check_ff;
      code_in      = code_ff;
      unique case (state_ff)
         slp_pkg::CTL_IDLE: begin
            if (req_tvalid) begin
               use_check_in = 1'b0;
               code_in      = slp_pkg::ST_ILLEGAL;
               state_in     = slp_pkg::CTL_CHECK;
               if (req_action == slp_pkg::ACTION_UNDO) begin
                  if (!stat.at_root) begin
                     use_check_in = 1'b1;
                     state_in     = slp_pkg::CTL_REMOVE_RIGHT;
                  end
               end else if (!stat.at_full) begin
                  if (stat.order_open && req_left && !req_right) begin
                     code_in = slp_pkg::ST_REJECTED;
                  end else begin
                     use_check_in = 1'b1;
                     state_in     = slp_pkg::CTL_PLACE_LEFT;
                  end
               end
            end
         end
         slp_pkg::CTL_PLACE_LEFT:   state_in = slp_pkg::CTL_PLACE_RIGHT;
         slp_pkg::CTL_PLACE_RIGHT:  state_in = slp_pkg::CTL_CHECK;
         slp_pkg::CTL_REMOVE_RIGHT: state_in = slp_pkg::CTL_REMOVE_LEFT;
         slp_pkg::CTL_REMOVE_LEFT:  state_in = slp_pkg::CTL_CHECK;
         slp_pkg::CTL_CHECK:        state_in = slp_pkg::CTL_REDUCE;
         slp_pkg::CTL_REDUCE:       if (out_free) state_in = slp_pkg::CTL_IDLE;
         default:                   state_in = slp_pkg::CTL_IDLE;
      endcase
   end

   always_comb begin
      cmd.left_spin  = left_ff;
      cmd.right_spin = right_ff;
      cmd.use_check  = use_check_ff;
      cmd.code       = code_ff;
      unique case (state_ff)
         slp_pkg::CTL_PLACE_LEFT:   cmd.op = slp_pkg::DP_PLACE_LEFT;
         slp_pkg::CTL_PLACE_RIGHT:  cmd.op = slp_pkg::DP_PLACE_RIGHT;
         slp_pkg::CTL_REMOVE_RIGHT: cmd.op = slp_pkg::DP_REMOVE_RIGHT;
         slp_pkg::CTL_REMOVE_LEFT:  cmd.op = slp_pkg::DP_REMOVE_LEFT;
         slp_pkg::CTL_CHECK:        cmd.op = slp_pkg::DP_CHECK;
         slp_pkg::CTL_REDUCE:       cmd.op = out_free ? slp_pkg::DP_REDUCE : slp_pkg::DP_IDLE;
         default:                   cmd.op = slp_pkg::DP_IDLE;
      endcase
      req_tready   = state_ff == slp_pkg::CTL_IDLE;
      rsp_valid_in = (rsp_valid_ff && !rsp_tready)
                     || ((state_ff == slp_pkg::CTL_REDUCE) && out_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slp_pkg::CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      use_check_ff <= use_check_in;
      code_ff      <= code_in;
      if (accept) begin
         left_ff  <= req_left;
         right_ff <= req_right;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
endmodule
`default_nettype wire

[sv/sidelobe_partial_sequence_pruner_core.sv]
// Top level of the sidelobe partial sequence pruner: register port and channel glue.
//
//  channel | ports        | direction | contents
//  request | req_t*       | in        | tuser: action; tdata: left_spin, right_spin
//  result  | rsp_t*       | out       | tdata: status, fill_depth, complete, peak
//  control | csr_p*       | in/out    | sidelobe_bound at byte address 0
//
// Assign and undo raise the result after the two position updates, the lane check and the
// registered peak tree at the reduce step; a rejected or illegal item raises it after the lane
// check and the reduce step alone. A new item is taken only after the last has left the reduce step.
// Reset restores the two fixed end positions and depth one.
// A result waiting on rsp_tready holds the next item at the reduce step.
`default_nettype none
module sidelobe_partial_sequence_pruner_core #(
   parameter int SEQ_LENGTH = 70
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [0] left_spin, [1] right_spin
   input  wire  [0:0]  req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [1:0] status, [8:2] fill_depth, [9] complete,
                                    // [16:10] peak_magnitude
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   slp_pkg::cmd_type  cmd;
   slp_pkg::stat_type stat;
   logic [6:0] bound_ff;
   logic [1:0] status;
   logic [6:0] fill_depth, peak_magnitude;
   logic       complete;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == slp_pkg::CSR_SIDELOBE_BOUND) ? {25'b0, bound_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff <= slp_pkg::BOUND_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == slp_pkg::CSR_SIDELOBE_BOUND)) begin
         bound_ff <= csr_pwdata[6:0];
      end
   end

   slp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser[0]),
      .req_left   (req_tdata[0]),
      .req_right  (req_tdata[1]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   slp_datapath #(.SEQ_LENGTH(SEQ_LENGTH)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sidelobe_bound (bound_ff),
      .stat           (stat),
      .status         (status),
      .fill_depth     (fill_depth),
      .complete       (complete),
      .peak_magnitude (peak_magnitude)
   );

   assign rsp_tdata = {7'b0, peak_magnitude, complete, fill_depth, status};
endmodule
`default_nettype wire

[sim/sidelobe_partial_sequence_pruner_checker.sv]
// Checker for the sidelobe partial sequence pruner: predicts each result and compares it.
module sidelobe_partial_sequence_pruner_checker #(
   parameter int SEQ_LENGTH = 70
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [7:0]  req_tdata,
   input  wire  [0:0]  req_tuser,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [23:0] rsp_tdata,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   input  wire         csr_pready,
   output int          errors,
   output int          pending
);

   localparam int HALF = SEQ_LENGTH / 2;

   typedef struct packed {
      logic [1:0] status;
      logic [6:0] fill_depth;
      logic       complete;
      logic [6:0] peak;
   } prune_result_type;

   prune_result_type expected_results[$];

   logic [6:0] bound;
   logic       spin [SEQ_LENGTH];
   logic       fixed [SEQ_LENGTH];
   int         corr [SEQ_LENGTH];
   int         prods [SEQ_LENGTH];
   int         depth;
   logic       rel_stack [HALF + 1];

   task automatic fix_position(input int pos, input logic s);
      int lag;
      spin[pos] = s;
      for (int o = 0; o < SEQ_LENGTH; o++) begin
         if (fixed[o]) begin
            lag = pos > o ? pos - o : o - pos;
            corr[lag] += (spin[o] == s) ? 1 : -1;
            prods[lag]++;
         end
      end
      fixed[pos] = 1'b1;
   endtask

   task automatic free_position(input int pos);
      int lag;
      fixed[pos] = 1'b0;
      for (int o = 0; o < SEQ_LENGTH; o++) begin
         if (fixed[o]) begin
            lag = pos > o ? pos - o : o - pos;
            corr[lag] -= (spin[o] == spin[pos]) ? 1 : -1;
            prods[lag]--;
         end
      end
   endtask

   function automatic logic lags_feasible();
      int mag;
      for (int lag = 1; lag < SEQ_LENGTH; lag++) begin
         mag = corr[lag] < 0 ? -corr[lag] : corr[lag];
         if (mag > int'(bound) + (SEQ_LENGTH - lag) - prods[lag]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic prune_step(input logic act, input logic ls, input logic rs);
      prune_result_type r;
      logic rel;
      int mag, pk;
      logic done;
      if (act == slp_pkg::ACTION_ASSIGN) begin
         if (depth >= HALF) r.status = slp_pkg::ST_ILLEGAL;
         else begin
            rel = rel_stack[depth];
            if (!rel && ls && !rs) r.status = slp_pkg::ST_REJECTED;
            else begin
               if (ls != rs) rel = 1'b1;
               fix_position(depth, ls);
               fix_position(SEQ_LENGTH - 1 - depth, rs);
               depth++;
               rel_stack[depth] = rel;
               r.status = lags_feasible() ? slp_pkg::ST_FEASIBLE : slp_pkg::ST_INFEASIBLE;
            end
         end
      end else begin
         if (depth <= 1) r.status = slp_pkg::ST_ILLEGAL;
         else begin
            free_position(SEQ_LENGTH - depth);
            free_position(depth - 1);
            rel_stack[depth] = 1'b0;
            depth--;
            r.status = lags_feasible() ? slp_pkg::ST_FEASIBLE : slp_pkg::ST_INFEASIBLE;
         end
      end
      pk = 0;
      done = 1'b1;
      for (int i = 1; i < SEQ_LENGTH; i++) begin
         mag = corr[i] < 0 ? -corr[i] : corr[i];
         if (mag > pk) pk = mag;
         if (mag > int'(bound)) done = 1'b0;
      end
      for (int i = 0; i < SEQ_LENGTH; i++) if (!fixed[i]) done = 1'b0;
      if (pk > 127) pk = 127;
      r.fill_depth = depth[6:0];
      r.complete   = done;
      r.peak       = pk[6:0];
      expected_results = {expected_results, r};
   endtask

   always @(posedge clock) begin
      prune_result_type e;
      prune_result_type a;
      if (reset) begin
         bound = slp_pkg::BOUND_RESET;
         for (int i = 0; i < SEQ_LENGTH; i++) begin
            spin[i] = 1'b0; fixed[i] = 1'b0; corr[i] = 0; prods[i] = 0;
         end
         for (int i = 0; i <= HALF; i++) rel_stack[i] = 1'b0;
         spin[0] = 1'b1; spin[SEQ_LENGTH-1] = 1'b1;
         fixed[0] = 1'b1; fixed[SEQ_LENGTH-1] = 1'b1;
         corr[SEQ_LENGTH-1] = 1; prods[SEQ_LENGTH-1] = 1;
         depth = 1;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == slp_pkg::CSR_SIDELOBE_BOUND)
            bound = csr_pwdata[6:0];
         if (rsp_tvalid && rsp_tready) begin
            a.status = rsp_tdata[1:0];
            a.fill_depth = rsp_tdata[8:2];
            a.complete = rsp_tdata[9];
            a.peak = rsp_tdata[16:10];
            if (expected_results.size() == 0) begin
               $display("%0t unexpected result %h", $time, rsp_tdata);
               errors++;
            end else begin
               e = expected_results.pop_front();
               if (a.status != e.status) begin
                  $display("%0t status exp %0d got %0d", $time, e.status, a.status);
                  errors++;
               end
               if (a.fill_depth != e.fill_depth) begin
                  $display("%0t fill_depth exp %0d got %0d", $time, e.fill_depth,
                           a.fill_depth);
                  errors++;
               end
               if (a.complete != e.complete) begin
                  $display("%0t complete exp %0d got %0d", $time, e.complete, a.complete);
                  errors++;
               end
               if (a.peak != e.peak) begin
                  $display("%0t peak exp %0d got %0d", $time, e.peak, a.peak);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            prune_step(req_tuser[0], req_tdata[0], req_tdata[1]);
      end
      pending = expected_results.size();
   end

   initial begin
      errors  = 0;
      pending = 0;
   end

endmodule

[sim/tb_sidelobe_partial_sequence_pruner_core.sv]
// Testbench top of the sidelobe partial sequence pruner: stimulus, stalls and verdict.
module tb_sidelobe_partial_sequence_pruner_core;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          errors;
   int          pending;
   int          idle_cycles = 0;
   int          burst_left = 0;

   always #5 clock = ~clock;

   sidelobe_partial_sequence_pruner_core DUT (.*);
   sidelobe_partial_sequence_pruner_checker u_checker (.*);

   // receiver: alternate between stretches of random stalls and no stalls
   always @(posedge clock) begin
      logic [7:0] phase;
      phase = 8'($time / 640);
      if (phase[1:0] == 2'd0) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(99) < 55);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_item(input logic act, input logic ls, input logic rs);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {6'b0, rs, ls};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(12);
         if ($urandom_range(3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_bound(input logic [6:0] v);
      drain();
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {slp_pkg::CSR_SIDELOBE_BOUND, 2'b00}; csr_pwdata <= {25'b0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic walk(input int count, input int assign_pct);
      for (int i = 0; i < count; i++)
         send_item(($urandom_range(99) < assign_pct) ? slp_pkg::ACTION_ASSIGN
                                                      : slp_pkg::ACTION_UNDO,
                   1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_item(slp_pkg::ACTION_UNDO, 1'b0, 1'b0);
      send_item(slp_pkg::ACTION_ASSIGN, 1'b1, 1'b0);
      send_item(slp_pkg::ACTION_ASSIGN, 1'b1, 1'b1);
      send_item(slp_pkg::ACTION_ASSIGN, 1'b0, 1'b0);
      send_item(slp_pkg::ACTION_ASSIGN, 1'b1, 1'b0);
      send_item(slp_pkg::ACTION_ASSIGN, 1'b0, 1'b1);
      send_item(slp_pkg::ACTION_ASSIGN, 1'b1, 1'b0);
      send_item(slp_pkg::ACTION_ASSIGN, 1'b0, 1'b0);
      repeat (5) send_item(slp_pkg::ACTION_UNDO, 1'b1, 1'b1);
      send_item(slp_pkg::ACTION_UNDO, 1'b0, 1'b0);
      write_bound(7'd69);
      walk(100, 90);
      walk(30, 50);
      write_bound(7'd0);
      walk(90, 55);
      write_bound(7'($urandom_range(1, 68)));
      walk(90, 65);
      write_bound(7'd2);
      walk(90, 60);
      write_bound(7'd69);
      walk(60, 85);
      write_bound(7'($urandom_range(69)));
      walk(40, 60);
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

[files.f]
sv/slp_pkg.sv
sv/slp_datapath.sv
sv/slp_ctrl.sv
sv/sidelobe_partial_sequence_pruner_core.sv
sim/sidelobe_partial_sequence_pruner_checker.sv
sim/tb_sidelobe_partial_sequence_pruner_core.sv
